### rtl/olte_pkg.sv
// olte_pkg: request and status codes, controller-to-datapath command and status types
// shared by olte_ctrl, olte_dp and ordered_list_table_engine_core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package olte_pkg;

   // request operation codes
   localparam logic [2:0] OP_APPEND       = 3'd0;
   localparam logic [2:0] OP_INSERT       = 3'd1;
   localparam logic [2:0] OP_FIND         = 3'd2;
   localparam logic [2:0] OP_REPLACE      = 3'd3;
   localparam logic [2:0] OP_REMOVE_FIRST = 3'd4;
   localparam logic [2:0] OP_REMOVE_ALL   = 3'd5;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_RANGE     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   // found_index when there is no match
   localparam logic [4:0] IDX_NONE = 5'h1F;

   // datapath working modes
   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_SCAN    = 3'd1;
   localparam logic [2:0] MODE_SHIFT   = 3'd2;
   localparam logic [2:0] MODE_WRITE   = 3'd3;
   localparam logic [2:0] MODE_COMPACT = 3'd4;
   localparam logic [2:0] MODE_EMIT    = 3'd5;
   localparam logic [2:0] MODE_SINGLE  = 3'd6;

   typedef struct packed {
      logic       load;        // latch request value and position
      logic       init;        // prepare sweep counters for the next mode
      logic       init_high;   // sweep starts at the list end (insert shift)
      logic [2:0] mode;
      logic       at_end;      // write goes after the last entry
      logic       grow;        // write adds an entry
      logic       first_only;  // compaction drops only the first match
      logic [1:0] status;      // status of a single result word
      logic       show_index;  // single result carries the match index
   } olte_cmd_type;

   typedef struct packed {
      logic full;
      logic pos_gt_cnt;
      logic pos_ge_cnt;
      logic sweep_done;
      logic found;
      logic none_left;
      logic out_free;
   } olte_stat_type;

endpackage

`default_nettype wire

### rtl/ordered_list_table_engine_core.sv
// ordered_list_table_engine_core: top level of the ordered list engine
// depends on olte_pkg, olte_ctrl and olte_dp
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake             payload
// req_      in         req_valid/req_stall   operation, value, position
// rsp_      out        rsp_valid/rsp_stall   status, found_index, entry_value, entry_valid,
//                                            list_length, removed_count, last
//
// one request at a time; req_stall is high from acceptance until the last result word
// is loaded, and after a list sweep until that sweep is done; one memory read port,
// one word out per cycle while the output is not stalled
// errors, find and a remove that leaves the list empty give a single word;
// a stalled output holds, the emit sweep waits on it
// synchronous active-high reset empties the list; entry memory has no reset
module ordered_list_table_engine_core
   import olte_pkg::*;
#(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_operation,
   input  wire logic signed [31:0] req_value,
   input  wire logic [4:0]         req_position,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic signed [4:0]       rsp_found_index,
   output logic signed [31:0]      rsp_entry_value,
   output logic                    rsp_entry_valid,
   output logic [4:0]              rsp_list_length,
   output logic [4:0]              rsp_removed_count,
   output logic                    rsp_last
);

   // command and status between sequencer and datapath
   olte_cmd_type  cmd;
   olte_stat_type stat;

   // sequencer: decode, range and fullness checks, phase order
   olte_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .cmd           (cmd),
      .stat          (stat)
   );

   // datapath: entry memory, scan, shift, compaction and the result word register
   olte_dp #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_value         (req_value),
      .req_position      (req_position),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_found_index   (rsp_found_index),
      .rsp_entry_value   (rsp_entry_value),
      .rsp_entry_valid   (rsp_entry_valid),
      .rsp_list_length   (rsp_list_length),
      .rsp_removed_count (rsp_removed_count),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

### rtl/olte_ctrl.sv
// olte_ctrl: request sequencer for the ordered list engine
// depends on olte_pkg; drives olte_dp through olte_cmd_type commands
`timescale 1ns / 1ps
`default_nettype none

module olte_ctrl
   import olte_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [2:0]    req_operation,
   output olte_cmd_type       cmd,
   input  wire olte_stat_type stat
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_SCAN    = 4'd2;
   localparam logic [3:0] S_SHIFT   = 4'd3;
   localparam logic [3:0] S_WRITE   = 4'd4;
   localparam logic [3:0] S_COMPACT = 4'd5;
   localparam logic [3:0] S_EMIT    = 4'd6;
   localparam logic [3:0] S_SINGLE  = 4'd7;

   logic [3:0] state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic [1:0] st_ff, st_in;
   logic       show_ff, show_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      st_in    = st_ff;
      show_in  = show_ff;
      cmd      = '0;
      cmd.mode = MODE_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in    = req_operation;
               // codes six and seven are dropped
               if (req_operation inside {[OP_APPEND:OP_REMOVE_ALL]}) begin
                  state_in = S_DECODE;
               end
            end
         end
         S_DECODE: begin
            case (op_ff)
               OP_APPEND: begin
                  if (stat.full) begin
                     st_in    = ST_FULL;
                     show_in  = 1'b0;
                     state_in = S_SINGLE;
                  end else begin
                     state_in = S_WRITE;
                  end
               end
               OP_INSERT: begin
                  // range is checked before fullness
                  if (stat.pos_gt_cnt) begin
                     st_in    = ST_RANGE;
                     show_in  = 1'b0;
                     state_in = S_SINGLE;
                  end else if (stat.full) begin
                     st_in    = ST_FULL;
                     show_in  = 1'b0;
                     state_in = S_SINGLE;
                  end else begin
                     cmd.init      = 1'b1;
                     cmd.init_high = 1'b1;
                     state_in      = S_SHIFT;
                  end
               end
               OP_REPLACE: begin
                  if (stat.pos_ge_cnt) begin
                     st_in    = ST_RANGE;
                     show_in  = 1'b0;
                     state_in = S_SINGLE;
                  end else begin
                     state_in = S_WRITE;
                  end
               end
               default: begin
                  cmd.init = 1'b1;
                  state_in = S_SCAN;
               end
            endcase
         end
         S_SCAN: begin
            cmd.mode = MODE_SCAN;
            if (stat.sweep_done) begin
               if (op_ff == OP_FIND) begin
                  st_in    = stat.found ? ST_OK : ST_NOT_FOUND;
                  show_in  = 1'b1;
                  state_in = S_SINGLE;
               end else if (!stat.found) begin
                  st_in    = ST_NOT_FOUND;
                  show_in  = 1'b0;
                  state_in = S_SINGLE;
               end else begin
                  cmd.init = 1'b1;
                  state_in = S_COMPACT;
               end
            end
         end
         S_SHIFT: begin
            cmd.mode = MODE_SHIFT;
            if (stat.sweep_done) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.mode   = MODE_WRITE;
            cmd.at_end = (op_ff == OP_APPEND);
            cmd.grow   = (op_ff != OP_REPLACE);
            cmd.init   = 1'b1;
            state_in   = S_EMIT;
         end
         S_COMPACT: begin
            cmd.mode       = MODE_COMPACT;
            cmd.first_only = (op_ff == OP_REMOVE_FIRST);
            if (stat.sweep_done) begin
               if (stat.none_left) begin
                  st_in    = ST_OK;
                  show_in  = 1'b0;
                  state_in = S_SINGLE;
               end else begin
                  cmd.init = 1'b1;
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            cmd.mode = MODE_EMIT;
            if (stat.sweep_done) begin
               state_in = S_IDLE;
            end
         end
         S_SINGLE: begin
            cmd.mode       = MODE_SINGLE;
            cmd.status     = st_ff;
            cmd.show_index = show_ff;
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      st_ff   <= st_in;
      show_ff <= show_in;
   end

endmodule

`default_nettype wire

### rtl/olte_dp.sv
// olte_dp: entry memory, sweep counters, compare unit and result word register
// depends on olte_pkg; commanded by olte_ctrl
`timescale 1ns / 1ps
`default_nettype none

module olte_dp
   import olte_pkg::*;
#(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic signed [31:0] req_value,
   input  wire logic [4:0]         req_position,
   input  wire olte_cmd_type       cmd,
   output olte_stat_type           stat,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic signed [4:0]       rsp_found_index,
   output logic signed [31:0]      rsp_entry_value,
   output logic                    rsp_entry_valid,
   output logic [4:0]              rsp_list_length,
   output logic [4:0]              rsp_removed_count,
   output logic                    rsp_last
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

   // entry store
   logic [VALUE_WIDTH-1:0] mem_ff [DEPTH];
   logic [VALUE_WIDTH-1:0] rdata_ff;

   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       rd_ff, rd_in;
   logic [CNT_W-1:0]       wr_ff, wr_in;
   logic [CNT_W-1:0]       pidx_ff, pidx_in;
   logic                   pend_ff, pend_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       first_ff, first_in;
   logic                   skip_ff, skip_in;
   logic [CNT_W-1:0]       removed_ff, removed_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [4:0]             pos_ff, pos_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [1:0]             status_ff;
   logic [4:0]             index_ff;
   logic [31:0]            entry_ff;
   logic                   entry_valid_ff;
   logic [4:0]             length_ff;
   logic [4:0]             removed_out_ff;
   logic                   last_ff;

   logic [VALUE_WIDTH+31:0] value_wide;
   logic [VALUE_WIDTH+31:0] rdata_wide;
   logic [CNT_W+4:0]        count_wide;
   logic [CNT_W+4:0]        removed_wide;
   logic [IDX_W+4:0]        first_wide;
   logic [CMP_W-1:0]        pos_cmp;
   logic [CMP_W-1:0]        cnt_cmp;
   logic [CNT_W-1:0]        rd_dec;
   logic [CNT_W-1:0]        rd_inc;
   logic [CNT_W:0]          pidx_next;
   logic                    rd_lt_cnt;
   logic                    rd_gt_pos;
   logic                    out_free;
   logic                    match;
   logic                    keep;
   logic                    rd_go;
   logic [IDX_W-1:0]        ra;
   logic                    we;
   logic [IDX_W-1:0]        wa;
   logic [VALUE_WIDTH-1:0]  wd;
   logic                    load_out;
   logic                    sweep_done;

   assign value_wide   = {{VALUE_WIDTH{1'b0}}, req_value};
   assign rdata_wide   = {32'd0, rdata_ff};
   assign count_wide   = {5'd0, count_ff};
   assign removed_wide = {5'd0, removed_ff};
   assign first_wide   = {5'd0, first_ff};
   assign pos_cmp      = CMP_W'(pos_ff);
   assign cnt_cmp      = CMP_W'(count_ff);
   assign rd_dec       = rd_ff - 1'b1;
   assign rd_inc       = rd_ff + 1'b1;
   assign pidx_next    = {1'b0, pidx_ff} + 1'b1;
   assign rd_lt_cnt    = (rd_ff < count_ff);
   assign rd_gt_pos    = (CMP_W'(rd_ff) > pos_cmp);
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign match        = (rdata_ff == value_ff);
   assign keep         = !(match && (!cmd.first_only || !skip_ff));

   assign sweep_done = !pend_ff && ((cmd.mode == MODE_SHIFT) ? !rd_gt_pos : !rd_lt_cnt);
   assign load_out   = ((cmd.mode == MODE_EMIT) && pend_ff && out_free)
                    || ((cmd.mode == MODE_SINGLE) && out_free);

   always_comb begin
      stat            = '0;
      stat.full       = (count_ff == CNT_W'(DEPTH));
      stat.pos_gt_cnt = (pos_cmp > cnt_cmp);
      stat.pos_ge_cnt = (pos_cmp >= cnt_cmp);
      stat.sweep_done = sweep_done;
      stat.found      = found_ff;
      stat.none_left  = (wr_ff == '0);
      stat.out_free   = out_free;
   end

   // memory port control
   always_comb begin
      rd_go = 1'b0;
      ra    = rd_ff[IDX_W-1:0];
      we    = 1'b0;
      wa    = pidx_ff[IDX_W-1:0];
      wd    = rdata_ff;
      case (cmd.mode)
         MODE_SCAN: begin
            rd_go = rd_lt_cnt;
         end
         MODE_COMPACT: begin
            rd_go = rd_lt_cnt;
            we    = pend_ff && keep;
            wa    = wr_ff[IDX_W-1:0];
         end
         MODE_EMIT: begin
            rd_go = rd_lt_cnt && (!pend_ff || out_free);
         end
         MODE_SHIFT: begin
            // walk down from the end, each word moves up one place
            rd_go = rd_gt_pos;
            ra    = rd_dec[IDX_W-1:0];
            we    = pend_ff;
         end
         MODE_WRITE: begin
            we = 1'b1;
            wa = cmd.at_end ? count_ff[IDX_W-1:0] : pos_cmp[IDX_W-1:0];
            wd = value_ff;
         end
         default: begin
            rd_go = 1'b0;
         end
      endcase
   end

   // sweep bookkeeping
   always_comb begin
      count_in   = count_ff;
      rd_in      = rd_ff;
      wr_in      = wr_ff;
      pidx_in    = pidx_ff;
      pend_in    = pend_ff;
      found_in   = found_ff;
      first_in   = first_ff;
      skip_in    = skip_ff;
      removed_in = removed_ff;
      value_in   = value_ff;
      pos_in     = pos_ff;

      if (cmd.load) begin
         value_in   = value_wide[VALUE_WIDTH-1:0];
         pos_in     = req_position;
         removed_in = '0;
      end

      if ((cmd.mode == MODE_SCAN) && pend_ff && match) begin
         found_in = 1'b1;
         if (!found_ff) begin
            first_in = pidx_ff[IDX_W-1:0];
         end
      end

      if ((cmd.mode == MODE_COMPACT) && pend_ff) begin
         if (keep) begin
            wr_in = wr_ff + 1'b1;
         end else begin
            skip_in = 1'b1;
         end
      end

      if ((cmd.mode == MODE_COMPACT) && sweep_done) begin
         count_in   = wr_ff;
         removed_in = count_ff - wr_ff;
      end

      if ((cmd.mode == MODE_WRITE) && cmd.grow) begin
         count_in = count_ff + 1'b1;
      end

      if (cmd.init) begin
         rd_in    = cmd.init_high ? count_ff : '0;
         wr_in    = '0;
         pend_in  = 1'b0;
         found_in = 1'b0;
         first_in = '0;
         skip_in  = 1'b0;
      end else if (rd_go) begin
         rd_in   = (cmd.mode == MODE_SHIFT) ? rd_dec : rd_inc;
         pidx_in = rd_ff;
         pend_in = 1'b1;
      end else if (cmd.mode == MODE_EMIT) begin
         pend_in = pend_ff && !out_free;
      end else begin
         pend_in = 1'b0;
      end
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wa] <= wd;
      end
      if (rd_go) begin
         rdata_ff <= mem_ff[ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff      <= rd_in;
      wr_ff      <= wr_in;
      pidx_ff    <= pidx_in;
      found_ff   <= found_in;
      first_ff   <= first_in;
      skip_ff    <= skip_in;
      removed_ff <= removed_in;
      value_ff   <= value_in;
      pos_ff     <= pos_in;
   end

   // result word register
   always_ff @(posedge clock) begin
      if (load_out) begin
         length_ff      <= count_wide[4:0];
         removed_out_ff <= removed_wide[4:0];
         if (cmd.mode == MODE_EMIT) begin
            status_ff      <= ST_OK;
            index_ff       <= IDX_NONE;
            entry_ff       <= rdata_wide[31:0];
            entry_valid_ff <= 1'b1;
            last_ff        <= (pidx_next == {1'b0, count_ff});
         end else begin
            status_ff      <= cmd.status;
            index_ff       <= (cmd.show_index && found_ff) ? first_wide[4:0] : IDX_NONE;
            entry_ff       <= '0;
            entry_valid_ff <= 1'b0;
            last_ff        <= 1'b1;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_found_index   = index_ff;
   assign rsp_entry_value   = entry_ff;
   assign rsp_entry_valid   = entry_valid_ff;
   assign rsp_list_length   = length_ff;
   assign rsp_removed_count = removed_out_ff;
   assign rsp_last          = last_ff;

endmodule

`default_nettype wire

### tb/ordered_list_table_engine_core_tb.sv
// ordered_list_table_engine_core_tb: self-checking testbench for the ordered list engine
// drives requests, predicts every result word from a shadow list and checks them in order
// depends on olte_pkg and ordered_list_table_engine_core
`timescale 1ns / 1ps

module ordered_list_table_engine_core_tb
   import olte_pkg::*;
();

   localparam int LIST_DEPTH  = 16;
   localparam int VALUE_BITS  = 32;
   localparam int IDLE_LIMIT  = 2000;  // cycles with no word moving on either channel
   localparam int DRAIN_WAIT  = 64;    // covers the time a remove on a full list holds the input
   localparam int RANDOM_REQS = 470;

   // one result word as the block presents it
   typedef struct {
      logic [1:0]  status;
      logic [4:0]  found_index;
      logic [31:0] entry_value;
      logic        entry_valid;
      logic [4:0]  list_length;
      logic [4:0]  removed_count;
      logic        last;
   } list_word_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [2:0]          req_operation;
   logic signed [31:0]  req_value;
   logic [4:0]          req_position;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [1:0]          rsp_status;
   logic signed [4:0]   rsp_found_index;
   logic signed [31:0]  rsp_entry_value;
   logic                rsp_entry_valid;
   logic [4:0]          rsp_list_length;
   logic [4:0]          rsp_removed_count;
   logic                rsp_last;

   // shadow of the list held by the block, head first
   logic signed [31:0]  shadow_list[$];
   // result words still owed by the block, oldest first
   list_word_type       expected_words[$];

   int  failures       = 0;
   int  requests_sent  = 0;
   int  words_checked  = 0;
   int  full_refusals  = 0;
   int  list_emptied   = 0;
   bit  steady         = 1'b0;  // both sides run without gaps while set

   ordered_list_table_engine_core #(
      .DEPTH       (LIST_DEPTH),
      .VALUE_WIDTH (VALUE_BITS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_value         (req_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_found_index   (rsp_found_index),
      .rsp_entry_value   (rsp_entry_value),
      .rsp_entry_valid   (rsp_entry_valid),
      .rsp_list_length   (rsp_list_length),
      .rsp_removed_count (rsp_removed_count),
      .rsp_last          (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------------------------

   // single word: errors and find
   function automatic void owe_single_word(input logic [1:0] status, input logic [4:0] index);
      list_word_type w;
      w.status        = status;
      w.found_index   = index;
      w.entry_value   = '0;
      w.entry_valid   = 1'b0;
      w.list_length   = 5'(shadow_list.size());
      w.removed_count = '0;
      w.last          = 1'b1;
      expected_words.push_back(w);
      if (status == ST_FULL) full_refusals++;
   endfunction

   // whole list after a successful change, or one empty word when nothing is left
   function automatic void owe_list_words(input logic [4:0] removed);
      list_word_type w;
      w.status        = ST_OK;
      w.found_index   = IDX_NONE;
      w.list_length   = 5'(shadow_list.size());
      w.removed_count = removed;
      if (shadow_list.size() == 0) begin
         w.entry_value = '0;
         w.entry_valid = 1'b0;
         w.last        = 1'b1;
         expected_words.push_back(w);
         list_emptied++;
         return;
      end
      foreach (shadow_list[i]) begin
         w.entry_value = shadow_list[i];
         w.entry_valid = 1'b1;
         w.last        = (i == shadow_list.size() - 1);
         expected_words.push_back(w);
      end
   endfunction

   // apply one accepted request to the shadow list and record the words it owes
   function automatic void predict_list_change(input logic [2:0] op, input logic [31:0] val,
                                               input logic [4:0] pos);
      int                 hit;
      int                 len;
      logic signed [31:0] kept[$];
      hit = -1;
      len = shadow_list.size();
      foreach (shadow_list[i])
         if (hit < 0 && shadow_list[i] == val) hit = i;
      case (op)
         OP_APPEND: begin
            if (len >= LIST_DEPTH) owe_single_word(ST_FULL, IDX_NONE);
            else begin
               shadow_list.push_back(val);
               owe_list_words('0);
            end
         end
         OP_INSERT: begin
            // range goes before fullness
            if (pos > len) owe_single_word(ST_RANGE, IDX_NONE);
            else if (len >= LIST_DEPTH) owe_single_word(ST_FULL, IDX_NONE);
            else begin
               shadow_list.insert(pos, val);
               owe_list_words('0);
            end
         end
         OP_FIND: begin
            if (hit < 0) owe_single_word(ST_NOT_FOUND, IDX_NONE);
            else owe_single_word(ST_OK, 5'(hit));
         end
         OP_REPLACE: begin
            if (pos >= len) owe_single_word(ST_RANGE, IDX_NONE);
            else begin
               shadow_list[pos] = val;
               owe_list_words('0);
            end
         end
         OP_REMOVE_FIRST: begin
            if (hit < 0) owe_single_word(ST_NOT_FOUND, IDX_NONE);
            else begin
               shadow_list.delete(hit);
               owe_list_words(5'd1);
            end
         end
         OP_REMOVE_ALL: begin
            // matches may lie anywhere; survivors keep their order
            if (hit < 0) owe_single_word(ST_NOT_FOUND, IDX_NONE);
            else begin
               foreach (shadow_list[i])
                  if (shadow_list[i] != val) kept.push_back(shadow_list[i]);
               shadow_list = kept;
               owe_list_words(5'(len - kept.size()));
            end
         end
         default: ;  // undefined codes: no word, no change
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------------------

   // valid stays high across back-to-back requests; it only drops for a gap
   task automatic send_request(input logic [2:0] op, input logic [31:0] val,
                               input logic [4:0] pos);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= val;
      req_position  <= pos;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_list_change(op, val, pos);
      requests_sent++;
   endtask

   // values that hit the list often, plus small repeats and the full 32-bit range
   function automatic logic [31:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40 && shadow_list.size() > 0)
         return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
      else if (roll < 70)
         return 32'($signed($urandom_range(0, 4)) - 2);
      else
         return $urandom;
   endfunction

   // ---------------------------------------------------------------------------------------
   // result side: stall drawing and checking
   // ---------------------------------------------------------------------------------------

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         failures++;
      end
   endtask

   initial begin : result_checker
      list_word_type want;
      int            hold_cycles;
      rsp_stall   <= 1'b0;
      hold_cycles = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_words.size() == 0) begin
               $error("result word with nothing expected (status %0d, value 0x%0h)",
                      rsp_status, rsp_entry_value);
               failures++;
            end else begin
               want = expected_words.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("found_index", 32'(want.found_index),
                           32'($unsigned(rsp_found_index)));
               check_field("entry_value", want.entry_value, $unsigned(rsp_entry_value));
               check_field("entry_valid", 32'(want.entry_valid), 32'(rsp_entry_valid));
               check_field("list_length", 32'(want.list_length), 32'(rsp_list_length));
               check_field("removed_count", 32'(want.removed_count),
                           32'(rsp_removed_count));
               check_field("last", 32'(want.last), 32'(rsp_last));
            end
            words_checked++;
            // stall for a fresh number of cycles after every word taken
            hold_cycles = steady ? 0 : $urandom_range(0, 5);
         end
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // a word must move on one channel or the other within the limit
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $error("no word moved for %0d cycles", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------

   // empty list straight after reset: lookups miss, positions are out of range
   task automatic test_empty_list();
      send_request(OP_FIND,         32'h0000_0000, 5'd0);
      send_request(OP_REMOVE_FIRST, 32'h0000_0000, 5'd0);
      send_request(OP_REPLACE,      32'h0000_0001, 5'd0);
      send_request(OP_INSERT,       32'h0000_0001, 5'd1);
      send_request(3'd6,            32'hFFFF_FFFF, 5'd31);  // undefined, ignored
      send_request(3'd7,            32'h5555_5555, 5'd16);  // undefined, ignored
   endtask

   // extreme values, head insert, insert at the end and duplicates set apart
   task automatic test_build_list();
      send_request(OP_APPEND, 32'h7FFF_FFFF, 5'd0);
      send_request(OP_APPEND, 32'h8000_0000, 5'd0);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 5'd0);   // head
      send_request(OP_INSERT, 32'h0000_0000, 5'd3);   // position equals length
      send_request(OP_INSERT, 32'hFFFF_FFFF, 5'd1);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 5'd3);   // -1 now at 0, 1 and 3
   endtask

   // find, remove first, remove all of scattered matches, down to an empty list
   task automatic test_removal();
      send_request(OP_FIND,         32'hFFFF_FFFF, 5'd0);
      send_request(OP_FIND,         32'h0000_0005, 5'd0);
      send_request(OP_REMOVE_FIRST, 32'h8000_0000, 5'd0);
      send_request(OP_REMOVE_ALL,   32'hFFFF_FFFF, 5'd0);
      send_request(OP_REPLACE,      32'h0000_002A, 5'd2);   // position equals length
      send_request(OP_REPLACE,      32'h0000_002A, 5'd1);
      send_request(OP_REMOVE_ALL,   32'h0000_0007, 5'd0);   // absent
      send_request(OP_REMOVE_ALL,   32'h0000_002A, 5'd0);
      send_request(OP_REMOVE_FIRST, 32'h7FFF_FFFF, 5'd0);   // list left empty
      send_request(OP_INSERT,       32'h0000_0001, 5'd31);
   endtask

   // mostly legal requests with random content; the list is steered between
   // full and empty so both refusal paths and long sweeps come up often
   task automatic test_random_traffic();
      int         sent;
      int         len;
      int         roll;
      bit         growing;
      logic [2:0] op;
      logic [4:0] pos;
      sent    = 0;
      growing = 1'b1;
      while (sent < RANDOM_REQS) begin
         if (sent % 40 == 0) steady = ($urandom_range(0, 3) == 0);
         len = shadow_list.size();
         if (len == LIST_DEPTH && $urandom_range(0, 2) == 0) growing = 1'b0;
         if (len == 0) growing = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            // noise: any code, any position, any value
            op = 3'($urandom_range(0, 7));
            send_request(op, $urandom, 5'($urandom_range(0, 31)));
         end else if (roll < (growing ? 60 : 22)) begin
            op  = ($urandom_range(0, 1) == 0) ? OP_APPEND : OP_INSERT;
            pos = 5'($urandom_range(0, len));
            send_request(op, pick_value(), pos);
         end else if (roll < 72) begin
            op  = ($urandom_range(0, 1) == 0) ? OP_FIND : OP_REPLACE;
            pos = 5'($urandom_range(0, (len > 0) ? len - 1 : 0));
            send_request(op, pick_value(), pos);
         end else begin
            op = ($urandom_range(0, 1) == 0) ? OP_REMOVE_FIRST : OP_REMOVE_ALL;
            send_request(op, pick_value(), 5'($urandom_range(0, 31)));
         end
         if (op <= OP_REMOVE_ALL) sent++;
      end
      steady = 1'b0;
   endtask

   // ---------------------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------------------

   initial begin : main_sequence
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_operation <= OP_APPEND;
      req_value     <= '0;
      req_position  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_build_list();
      test_removal();
      test_random_traffic();
      req_valid <= 1'b0;

      // the watchdog catches a block that never delivers what is owed
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d requests sent, %0d result words checked", requests_sent, words_checked);
      $display("list refused as full %0d times, emptied by removal %0d times",
               full_refusals, list_emptied);
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### filelist.f
rtl/olte_pkg.sv
rtl/olte_ctrl.sv
rtl/olte_dp.sv
rtl/ordered_list_table_engine_core.sv
tb/ordered_list_table_engine_core_tb.sv
